[rtl/bdc_pkg.sv]
// Shared types, constants and calendar tables for the business day counter.
package bdc_pkg;

   localparam int DAY_W      = 5;
   localparam int MONTH_W    = 4;
   localparam int YEAR_W     = 14;
   localparam int COUNT_W    = 22;
   localparam int MASK_W     = 7;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int DIV_W      = 22;
   localparam int DIVISOR_W  = 9;
   localparam int RECIP_W    = 23;
   localparam int PROD_W     = 45;
   localparam int CENT_SHIFT = 20;
   localparam int QUAD_SHIFT = 22;
   localparam int WEEK_SHIFT = 25;

   localparam logic [MASK_W-1:0]    MASK_RESET    = 7'd96;
   localparam logic [DIVISOR_W-1:0] DIVISOR_CENT  = 9'd100;
   localparam logic [DIVISOR_W-1:0] DIVISOR_QUAD  = 9'd400;
   localparam logic [DIVISOR_W-1:0] DIVISOR_WEEK  = 9'd7;
   localparam logic [RECIP_W-1:0]   RECIP_CENT    = 23'd10486;
   localparam logic [RECIP_W-1:0]   RECIP_WEEK    = 23'd4793491;
   localparam logic [YEAR_W-1:0]    YEAR_MAX      = 14'd9999;
   localparam logic [CSR_ADDR_W-1:0] ADDR_WEEKEND_MASK = 3'd0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_F100,
      ST_DIV_F400,
      ST_DIV_T100,
      ST_DIV_T400,
      ST_SERIAL,
      ST_SPAN,
      ST_DIV_WD,
      ST_DIV_N,
      ST_COUNT,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      DIV_F100,
      DIV_F400,
      DIV_T100,
      DIV_T400,
      DIV_WD,
      DIV_N
   } div_op_type;

   typedef struct packed {
      logic       load;
      logic       div_run;
      div_op_type div_op;
      logic       calc_serial;
      logic       calc_span;
      logic       calc_count;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic rsp_free;
   } status_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
      logic [8:0] st;
      unique case (m)
         4'd1:    st = 9'd0;
         4'd2:    st = 9'd31;
         4'd3:    st = 9'd59;
         4'd4:    st = 9'd90;
         4'd5:    st = 9'd120;
         4'd6:    st = 9'd151;
         4'd7:    st = 9'd181;
         4'd8:    st = 9'd212;
         4'd9:    st = 9'd243;
         4'd10:   st = 9'd273;
         4'd11:   st = 9'd304;
         4'd12:   st = 9'd334;
         default: st = 9'd0;
      endcase
      return st;
   endfunction

endpackage

[rtl/business_day_counter_core.sv]
// Top level of the business day counter: register port, controller and datapath.
//
// Input channel req_*: one item holds a start date and an end date (excluded).
// Result channel rsp_*: one item per input, the count of business days in
// rsp_tdata and the bad-date flag in rsp_tuser; a bad date gives a zero count.
// Register port csr_*: weekend_mask at byte address 0, bit d marks weekday d
// (0 Sunday) as a non-business day; write only while no item is in flight.
//
// The same steps run for every item, whatever the span, and no new item is taken
// until the result of the last one is loaded; the next item is accepted the cycle
// after the result is loaded. Each item runs six constant divisions (by 100 and
// 400 for each year, by 7 for the start weekday and the week count), each a registered
// reciprocal-multiply quotient and then the remainder, plus serial numbers, span, count and load.
//
// Reset clears the controller, the divider phase and the output valid, and
// sets weekend_mask to Friday and Saturday. When the receiver stalls, the result
// holds in the output register; the block accepts and works on the next item
// and waits at its end until the output register is free.
module business_day_counter_core (
   input  logic                                clock,
   input  logic                                reset,
   // from_day[4:0], from_month[8:5], from_year[22:9],
   // to_day[27:23], to_month[31:28], to_year[45:32], zero[47:46]
   input  logic [bdc_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // business_days[21:0], zero[23:22]
   output logic [bdc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // bad_date[0]
   output logic [0:0]                          rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bdc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [bdc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [bdc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import bdc_pkg::*;

   logic [MASK_W-1:0] weekend_mask_ff;
   logic              csr_write;
   cmd_type           cmd;
   status_type        status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         weekend_mask_ff <= MASK_RESET;
      end else if (csr_write && (csr_paddr[2] == ADDR_WEEKEND_MASK[2])) begin
         weekend_mask_ff <= csr_pwdata[MASK_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == ADDR_WEEKEND_MASK[2])
                       ? CSR_DATA_W'(weekend_mask_ff) : '0;

   bdc_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bdc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_tdata    (req_tdata),
      .weekend_mask (weekend_mask_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

   a_one_item_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted twice in a row");

   a_bad_date_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[COUNT_W-1:0] == '0)
      else $error("bad date with nonzero count");

   a_mask_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && (csr_paddr[2] == ADDR_WEEKEND_MASK[2])
      |=> weekend_mask_ff == $past(csr_pwdata[MASK_W-1:0]))
      else $error("weekend mask write lost");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !rsp_tvalid || rsp_tready)
      else $error("result overwritten while stalled");

endmodule

[rtl/bdc_controller.sv]
// Sequencer that steps one item through divisions, serial numbers and the count.
module bdc_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  bdc_pkg::status_type status,
   output bdc_pkg::cmd_type    cmd
);
   import bdc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.div_op      = DIV_F100;
      req_tready      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV_F100;
            end
         end
         ST_DIV_F100: begin
            cmd.div_run = 1'b1;
            cmd.div_op  = DIV_F100;
            if (status.div_done) state_in = ST_DIV_F400;
         end
         ST_DIV_F400: begin
            cmd.div_run = 1'b1;
            cmd.div_op  = DIV_F400;
            if (status.div_done) state_in = ST_DIV_T100;
         end
         ST_DIV_T100: begin
            cmd.div_run = 1'b1;
            cmd.div_op  = DIV_T100;
            if (status.div_done) state_in = ST_DIV_T400;
         end
         ST_DIV_T400: begin
            cmd.div_run = 1'b1;
            cmd.div_op  = DIV_T400;
            if (status.div_done) state_in = ST_SERIAL;
         end
         ST_SERIAL: begin
            cmd.calc_serial = 1'b1;
            state_in        = ST_SPAN;
         end
         ST_SPAN: begin
            cmd.calc_span = 1'b1;
            state_in      = ST_DIV_WD;
         end
         ST_DIV_WD: begin
            cmd.div_run = 1'b1;
            cmd.div_op  = DIV_WD;
            if (status.div_done) state_in = ST_DIV_N;
         end
         ST_DIV_N: begin
            cmd.div_run = 1'b1;
            cmd.div_op  = DIV_N;
            if (status.div_done) state_in = ST_COUNT;
         end
         ST_COUNT: begin
            cmd.calc_count = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[rtl/bdc_datapath.sv]
// Datapath: input capture, reciprocal constant divider, serial numbers, count, output register.
module bdc_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  bdc_pkg::cmd_type                  cmd,
   output bdc_pkg::status_type               status,
   input  logic [bdc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [bdc_pkg::MASK_W-1:0]        weekend_mask,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bdc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [0:0]                        rsp_tuser
);
   import bdc_pkg::*;

   logic [DAY_W-1:0]   from_day_ff, to_day_ff;
   logic [MONTH_W-1:0] from_month_ff, to_month_ff;
   logic [YEAR_W-1:0]  from_year_ff, to_year_ff;

   logic                 phase_ff, phase_in;
   logic [DIV_W-1:0]     quot_ff, quot_in;
   logic [YEAR_W-1:0]    from_p, to_p;
   logic [DIV_W-1:0]     dividend;
   logic [DIVISOR_W-1:0] divisor;
   logic [RECIP_W-1:0]   recip;
   logic [PROD_W-1:0]    product;
   logic [DIV_W-1:0]     q_sel;
   logic [DIV_W-1:0]     back;
   logic [DIV_W-1:0]     rem_full;
   logic [DIVISOR_W-1:0] r_fin;

   logic [7:0] fq100_ff, tq100_ff;
   logic [6:0] fr100_ff, tr100_ff;
   logic [5:0] fq400_ff, tq400_ff;
   logic [8:0] fr400_ff, tr400_ff;
   logic [2:0] wd_ff, nr_ff;
   logic [18:0] nq_ff;

   logic [COUNT_W-1:0] s1_ff, s2_ff, n_ff;
   logic               bad_ff, lt_ff;
   logic [COUNT_W-1:0] count_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_bad_ff;

   logic               from_leap, to_leap, from_ok, to_ok;
   logic [COUNT_W-1:0] from_serial, to_serial;
   logic [2:0]         per_week;
   logic [2:0]         partial;
   logic [COUNT_W-1:0] count_calc;

   function automatic logic [COUNT_W-1:0] serial_of(
      input logic [DAY_W-1:0]   d,
      input logic [MONTH_W-1:0] m,
      input logic [YEAR_W-1:0]  y,
      input logic [7:0]         q100,
      input logic [5:0]         q400,
      input logic               lp
   );
      logic [YEAR_W-1:0]  p;
      logic [COUNT_W:0]   base;
      logic [COUNT_W-1:0] s;
      p    = y - YEAR_W'(1);
      base = (COUNT_W+1)'(p) * (COUNT_W+1)'(365);
      s    = base[COUNT_W-1:0] + COUNT_W'(p[YEAR_W-1:2]) - COUNT_W'(q100) + COUNT_W'(q400)
             + COUNT_W'(month_start(m)) + COUNT_W'(lp && (m > 4'd2)) + COUNT_W'(d)
             - COUNT_W'(1);
      return s;
   endfunction

   function automatic logic date_ok(
      input logic [DAY_W-1:0]   d,
      input logic [MONTH_W-1:0] m,
      input logic [YEAR_W-1:0]  y,
      input logic               lp
   );
      logic [DAY_W-1:0] len;
      len = month_len(m) + DAY_W'(lp && (m == 4'd2));
      return (y != '0) && (y <= YEAR_MAX) && (m != '0) && (m <= 4'd12)
             && (d != '0) && (d <= len);
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         from_day_ff   <= req_tdata[4:0];
         from_month_ff <= req_tdata[8:5];
         from_year_ff  <= req_tdata[22:9];
         to_day_ff     <= req_tdata[27:23];
         to_month_ff   <= req_tdata[31:28];
         to_year_ff    <= req_tdata[45:32];
      end
   end

   assign from_p = from_year_ff - YEAR_W'(1);
   assign to_p   = to_year_ff - YEAR_W'(1);

   always_comb begin
      unique case (cmd.div_op)
         DIV_F100: begin
            dividend = DIV_W'(from_p);
            divisor  = DIVISOR_CENT;
            recip    = RECIP_CENT;
         end
         DIV_F400: begin
            dividend = DIV_W'(from_p);
            divisor  = DIVISOR_QUAD;
            recip    = RECIP_CENT;
         end
         DIV_T100: begin
            dividend = DIV_W'(to_p);
            divisor  = DIVISOR_CENT;
            recip    = RECIP_CENT;
         end
         DIV_T400: begin
            dividend = DIV_W'(to_p);
            divisor  = DIVISOR_QUAD;
            recip    = RECIP_CENT;
         end
         DIV_WD: begin
            dividend = s1_ff + DIV_W'(1);
            divisor  = DIVISOR_WEEK;
            recip    = RECIP_WEEK;
         end
         DIV_N: begin
            dividend = n_ff;
            divisor  = DIVISOR_WEEK;
            recip    = RECIP_WEEK;
         end
         default: begin
            dividend = '0;
            divisor  = DIVISOR_WEEK;
            recip    = RECIP_WEEK;
         end
      endcase
      product = PROD_W'(dividend) * PROD_W'(recip);
      unique case (cmd.div_op)
         DIV_F100, DIV_T100: q_sel = DIV_W'(product[CENT_SHIFT+7:CENT_SHIFT]);
         DIV_F400, DIV_T400: q_sel = DIV_W'(product[QUAD_SHIFT+5:QUAD_SHIFT]);
         default:            q_sel = DIV_W'(product[PROD_W-1:WEEK_SHIFT]);
      endcase
      back     = quot_ff * DIV_W'(divisor);
      rem_full = dividend - back;
      r_fin    = rem_full[DIVISOR_W-1:0];
      quot_in  = quot_ff;
      phase_in = phase_ff;
      if (cmd.div_run) begin
         if (!phase_ff) begin
            quot_in = q_sel;
         end
         phase_in = !phase_ff;
      end
   end

   assign status.div_done = cmd.div_run && phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
      quot_ff <= quot_in;
   end

   always_ff @(posedge clock) begin
      if (status.div_done) begin
         unique case (cmd.div_op)
            DIV_F100: begin fq100_ff <= quot_ff[7:0]; fr100_ff <= r_fin[6:0]; end
            DIV_F400: begin fq400_ff <= quot_ff[5:0]; fr400_ff <= r_fin[8:0]; end
            DIV_T100: begin tq100_ff <= quot_ff[7:0]; tr100_ff <= r_fin[6:0]; end
            DIV_T400: begin tq400_ff <= quot_ff[5:0]; tr400_ff <= r_fin[8:0]; end
            DIV_WD:   wd_ff <= r_fin[2:0];
            DIV_N:    begin nq_ff <= quot_ff[18:0]; nr_ff <= r_fin[2:0]; end
            default:  ;
         endcase
      end
   end

   assign from_leap = ((from_year_ff[1:0] == 2'd0) && (fr100_ff != 7'd99))
                      || (fr400_ff == 9'd399);
   assign to_leap   = ((to_year_ff[1:0] == 2'd0) && (tr100_ff != 7'd99))
                      || (tr400_ff == 9'd399);
   assign from_ok   = date_ok(from_day_ff, from_month_ff, from_year_ff, from_leap);
   assign to_ok     = date_ok(to_day_ff, to_month_ff, to_year_ff, to_leap);
   assign from_serial = serial_of(from_day_ff, from_month_ff, from_year_ff,
                                  fq100_ff, fq400_ff, from_leap);
   assign to_serial   = serial_of(to_day_ff, to_month_ff, to_year_ff,
                                  tq100_ff, tq400_ff, to_leap);

   always_ff @(posedge clock) begin
      if (cmd.calc_serial) begin
         s1_ff  <= from_serial;
         s2_ff  <= to_serial;
         bad_ff <= !(from_ok && to_ok);
      end
      if (cmd.calc_span) begin
         n_ff  <= s2_ff - s1_ff;
         lt_ff <= s1_ff < s2_ff;
      end
      if (cmd.calc_count) begin
         count_ff <= count_calc;
      end
   end

   always_comb begin
      logic [3:0] idx;
      logic [2:0] wday;
      per_week = 3'd7 - 3'($countones(weekend_mask));
      partial  = '0;
      for (int i = 0; i < 6; i++) begin
         idx  = 4'(wd_ff) + 4'(i);
         wday = (idx >= 4'd7) ? 3'(idx - 4'd7) : idx[2:0];
         if ((3'(i) < nr_ff) && !weekend_mask[wday]) partial = partial + 3'd1;
      end
      count_calc = (bad_ff || !lt_ff) ? '0
                 : COUNT_W'(nq_ff) * COUNT_W'(per_week) + COUNT_W'(partial);
   end

   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.rsp_load) begin
         rsp_count_ff <= count_ff;
         rsp_bad_ff   <= bad_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_count_ff);
   assign rsp_tuser  = rsp_bad_ff;

endmodule

[tb/tb.sv]
// Self-checking testbench for business_day_counter_core: date spans in, business day counts out.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bdc_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 200;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE = 3'd4;

   typedef struct {
      logic [DAY_W-1:0]   from_day;
      logic [MONTH_W-1:0] from_month;
      logic [YEAR_W-1:0]  from_year;
      logic [DAY_W-1:0]   to_day;
      logic [MONTH_W-1:0] to_month;
      logic [YEAR_W-1:0]  to_year;
   } date_span_type;

   typedef struct {
      logic [COUNT_W-1:0] days;
      logic               bad;
   } day_count_type;

   typedef struct {
      date_span_type span;
      bit            known;
      day_count_type want;
   } span_case_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   logic [MASK_W-1:0] weekend_days = MASK_RESET;
   day_count_type pending_counts[$];
   int mismatches = 0;
   int idle_cycles = 0;
   int rsp_hold = 0;
   bit req_idle = 1'b1;
   bit rsp_idle = 1'b1;

   span_case_type directed_spans [21] = '{
      '{'{1, 1, 1, 1, 1, 1}, 1, '{0, 0}},
      '{'{1, 1, 1, 2, 1, 1}, 1, '{1, 0}},
      '{'{1, 1, 2024, 8, 1, 2024}, 1, '{5, 0}},
      '{'{31, 12, 9999, 1, 1, 1}, 1, '{0, 0}},
      '{'{1, 1, 1, 31, 12, 9999}, 0, '{0, 0}},
      '{'{31, 12, 9998, 31, 12, 9999}, 0, '{0, 0}},
      '{'{0, 1, 2000, 1, 1, 2001}, 1, '{0, 1}},
      '{'{1, 0, 2000, 1, 1, 2001}, 1, '{0, 1}},
      '{'{1, 13, 2000, 1, 1, 2001}, 1, '{0, 1}},
      '{'{1, 1, 0, 1, 1, 2001}, 1, '{0, 1}},
      '{'{1, 1, 2000, 1, 1, 10000}, 1, '{0, 1}},
      '{'{31, 15, 16383, 31, 15, 16383}, 1, '{0, 1}},
      '{'{0, 0, 0, 0, 0, 0}, 1, '{0, 1}},
      '{'{29, 2, 2000, 1, 3, 2000}, 0, '{0, 0}},
      '{'{29, 2, 1900, 1, 3, 1900}, 1, '{0, 1}},
      '{'{29, 2, 2024, 1, 3, 2024}, 0, '{0, 0}},
      '{'{1, 1, 2023, 29, 2, 2023}, 1, '{0, 1}},
      '{'{1, 4, 2023, 31, 4, 2023}, 1, '{0, 1}},
      '{'{30, 4, 2023, 1, 5, 2023}, 0, '{0, 0}},
      '{'{31, 12, 2023, 1, 1, 2024}, 0, '{0, 0}},
      '{'{31, 1, 2024, 1, 3, 2025}, 0, '{0, 0}}
   };

   business_day_counter_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic bit leap_year(int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
   endfunction

   function automatic int unsigned month_days(int unsigned m, int unsigned y);
      case (m)
         2:          return leap_year(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:    return 31;
      endcase
   endfunction

   function automatic bit date_ok(int unsigned d, int unsigned m, int unsigned y);
      if (y < 1 || y > 9999 || m < 1 || m > 12)
         return 1'b0;
      return d >= 1 && d <= month_days(m, y);
   endfunction

   // day 0 is the first of January of year 1, a Monday
   function automatic int unsigned day_number(int unsigned d, int unsigned m, int unsigned y);
      int unsigned p;
      int unsigned n;
      p = y - 1;
      n = 365 * p + p / 4 - p / 100 + p / 400;
      for (int unsigned k = 1; k < m; k++)
         n += month_days(k, y);
      return n + d - 1;
   endfunction

   function automatic day_count_type count_business_days(date_span_type s,
                                                         logic [MASK_W-1:0] mask);
      day_count_type r;
      int unsigned first;
      int unsigned last;
      int unsigned span_len;
      int unsigned wd;
      int unsigned total;
      r.days = '0;
      r.bad = 1'b0;
      if (!date_ok(s.from_day, s.from_month, s.from_year) ||
          !date_ok(s.to_day, s.to_month, s.to_year)) begin
         r.bad = 1'b1;
         return r;
      end
      first = day_number(s.from_day, s.from_month, s.from_year);
      last = day_number(s.to_day, s.to_month, s.to_year);
      if (first >= last)
         return r;
      span_len = last - first;
      wd = (first + 1) % 7;
      total = (span_len / 7) * (7 - $countones(mask));
      for (int unsigned i = 0; i < span_len % 7; i++) begin
         if (!mask[wd])
            total++;
         wd = (wd + 1) % 7;
      end
      r.days = total[COUNT_W-1:0];
      return r;
   endfunction

   function automatic void random_date(output logic [DAY_W-1:0] d,
                                       output logic [MONTH_W-1:0] m,
                                       output logic [YEAR_W-1:0] y);
      int unsigned yr;
      int unsigned mo;
      case ($urandom_range(0, 3))
         0:       yr = $urandom_range(1, 9999);
         1:       yr = $urandom_range(1, 4);
         2:       yr = $urandom_range(9996, 9999);
         default: yr = $urandom_range(1896, 2104);
      endcase
      mo = $urandom_range(1, 12);
      y = yr[YEAR_W-1:0];
      m = mo[MONTH_W-1:0];
      d = DAY_W'($urandom_range(1, month_days(mo, yr)));
   endfunction

   function automatic void break_date(inout logic [DAY_W-1:0] d,
                                      inout logic [MONTH_W-1:0] m,
                                      inout logic [YEAR_W-1:0] y);
      int unsigned len;
      int unsigned v;
      len = month_days(m, y);
      case ($urandom_range(0, 2))
         0: begin
            if (len == 31 || $urandom_range(0, 1) == 0)
               d = '0;
            else
               d = DAY_W'($urandom_range(len + 1, 31));
         end
         1: begin
            v = $urandom_range(12, 15);
            m = (v == 12) ? '0 : MONTH_W'(v);
         end
         default: y = ($urandom_range(0, 1) == 0) ? '0 : YEAR_W'($urandom_range(10000, 16383));
      endcase
   endfunction

   function automatic date_span_type random_span();
      date_span_type s;
      logic [REQ_DATA_W-1:0] raw;
      int unsigned shape;
      int unsigned yr;
      shape = $urandom_range(0, 99);
      if (shape < 5) begin
         raw = REQ_DATA_W'({$urandom, $urandom});
         {s.to_year, s.to_month, s.to_day, s.from_year, s.from_month, s.from_day} = raw[45:0];
         return s;
      end
      random_date(s.from_day, s.from_month, s.from_year);
      case ($urandom_range(0, 9))
         0: begin
            s.to_day = s.from_day;
            s.to_month = s.from_month;
            s.to_year = s.from_year;
         end
         1, 2, 3, 4: begin
            random_date(s.to_day, s.to_month, s.to_year);
            yr = s.from_year + $urandom_range(0, 1);
            if (yr > 9999)
               yr = 9999;
            s.to_year = yr[YEAR_W-1:0];
            if (s.to_day > month_days(s.to_month, yr))
               s.to_day = DAY_W'(month_days(s.to_month, yr));
         end
         default: random_date(s.to_day, s.to_month, s.to_year);
      endcase
      if (shape < 15) begin
         if ($urandom_range(0, 1) == 0)
            break_date(s.from_day, s.from_month, s.from_year);
         else
            break_date(s.to_day, s.to_month, s.to_year);
      end
      return s;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
      mismatches++;
   endtask

   task automatic check_count();
      day_count_type want;
      if (pending_counts.size() == 0) begin
         report_mismatch("unexpected item", rsp_tdata, 0);
      end else begin
         want = pending_counts.pop_front();
         if (rsp_tdata !== RSP_DATA_W'(want.days))
            report_mismatch("business_days", rsp_tdata, want.days);
         if (rsp_tuser[0] !== want.bad)
            report_mismatch("bad_date", rsp_tuser[0], want.bad);
      end
   endtask

   task automatic send_span(date_span_type s, day_count_type want);
      if (req_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tdata <= {2'b00, s.to_year, s.to_month, s.to_day, s.from_year, s.from_month, s.from_day};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_counts.push_back(want);
   endtask

   task automatic send_random(int n);
      date_span_type s;
      repeat (n) begin
         s = random_span();
         send_span(s, count_business_days(s, weekend_days));
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
   endtask

   task automatic csr_access(bit wr, logic [CSR_ADDR_W-1:0] addr,
                             logic [CSR_DATA_W-1:0] wdata, output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, addr, value, rd);
      if (addr == ADDR_WEEKEND_MASK)
         weekend_days = value[MASK_W-1:0];
      csr_access(1'b0, ADDR_WEEKEND_MASK, '0, rd);
      if (rd[MASK_W-1:0] !== weekend_days)
         report_mismatch("weekend_mask readback", rd[MASK_W-1:0], weekend_days);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_count();
         if (rsp_hold > 1) begin
            rsp_hold <= rsp_hold - 1;
         end else if (rsp_hold == 1) begin
            rsp_hold <= 0;
            rsp_tready <= 1'b1;
         end else if (rsp_idle && $urandom_range(0, 7) == 0) begin
            rsp_hold <= $urandom_range(1, 17);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] rd;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      csr_access(1'b0, ADDR_WEEKEND_MASK, '0, rd);
      if (rd[MASK_W-1:0] !== weekend_days)
         report_mismatch("weekend_mask after reset", rd[MASK_W-1:0], weekend_days);

      foreach (directed_spans[i]) begin
         if (directed_spans[i].known)
            send_span(directed_spans[i].span, directed_spans[i].want);
         else
            send_span(directed_spans[i].span,
                      count_business_days(directed_spans[i].span, weekend_days));
      end

      drain();
      write_reg(ADDR_WEEKEND_MASK, 32'h0000_0000);
      send_random(240);

      drain();
      write_reg(ADDR_WEEKEND_MASK, 32'h0000_007F);
      write_reg(ADDR_SPARE, 32'h0000_0015);
      send_random(200);

      drain();
      write_reg(ADDR_WEEKEND_MASK, 32'hFFFF_FFC1);
      send_random(240);

      drain();
      write_reg(ADDR_WEEKEND_MASK, $urandom);
      send_random(250);

      drain();
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      write_reg(ADDR_WEEKEND_MASK, $urandom);
      send_random(300);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_counts.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

[sim.f]
rtl/bdc_pkg.sv
rtl/bdc_controller.sv
rtl/bdc_datapath.sv
rtl/business_day_counter_core.sv
tb/tb.sv
